// ===== design/qrp_pkg.sv =====
// ----------------------------------------------------------------------------
// qrp_pkg: shared types and constants for the quaternion point rotator
// Holds the fixed widths of the quaternion path, the register map and the
// types used between the pipeline sections.
// ----------------------------------------------------------------------------
package qrp_pkg;

  // Quaternion components are 16-bit two's complement values.
  localparam int QUAT_W = 16;
  // Scaled rotation matrix entries: every entry is bounded by the norm.
  localparam int MAT_W  = 35;
  // Squared norm, at most 2^32.
  localparam int NRM_W  = 33;
  // Divider partial remainder (below the norm, doubled plus one bit).
  localparam int REM_W  = 34;
  // Split point of a matrix entry for the partial products.
  localparam int MLO_W  = 17;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indexes.
  localparam logic [1:0] REG_QUAT_W = 2'd0;
  localparam logic [1:0] REG_QUAT_X = 2'd1;
  localparam logic [1:0] REG_QUAT_Y = 2'd2;
  localparam logic [1:0] REG_QUAT_Z = 2'd3;

  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [MAT_W-1:0]  mat_t;
  typedef logic [NRM_W-1:0]         norm_t;

endpackage

// ===== design/qrp_matrix.sv =====
// ----------------------------------------------------------------------------
// qrp_matrix: scaled rotation matrix
// Two register stages: the ten quaternion products, then the squared norm
// and the nine matrix entries scaled by the norm.
// ----------------------------------------------------------------------------
module qrp_matrix
  import qrp_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  quat_t      qw,
  input  quat_t      qx,
  input  quat_t      qy,
  input  quat_t      qz,
  output norm_t      norm,
  output mat_t [8:0] mat
);

  logic signed [2*QUAT_W-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
  mat_t nsum;

  function automatic mat_t sx(input logic signed [2*QUAT_W-1:0] a);
    return MAT_W'(a);
  endfunction

  // First stage: the component products.
  always_ff @(posedge clk) begin
    if (en) begin
      ww <= qw * qw;
      xx <= qx * qx;
      yy <= qy * qy;
      zz <= qz * qz;
      xy <= qx * qy;
      wz <= qw * qz;
      xz <= qx * qz;
      wy <= qw * qy;
      yz <= qy * qz;
      wx <= qw * qx;
    end
  end

  assign nsum = sx(ww) + sx(xx) + sx(yy) + sx(zz);

  // Second stage: norm and matrix entries, row by row.
  always_ff @(posedge clk) begin
    if (en) begin
      norm   <= NRM_W'(nsum);
      mat[0] <= sx(ww) + sx(xx) - sx(yy) - sx(zz);
      mat[1] <= (sx(xy) - sx(wz)) <<< 1;
      mat[2] <= (sx(xz) + sx(wy)) <<< 1;
      mat[3] <= (sx(xy) + sx(wz)) <<< 1;
      mat[4] <= sx(ww) - sx(xx) + sx(yy) - sx(zz);
      mat[5] <= (sx(yz) - sx(wx)) <<< 1;
      mat[6] <= (sx(xz) - sx(wy)) <<< 1;
      mat[7] <= (sx(yz) + sx(wx)) <<< 1;
      mat[8] <= sx(ww) - sx(xx) - sx(yy) + sx(zz);
    end
  end

endmodule

// ===== design/qrp_dot.sv =====
// ----------------------------------------------------------------------------
// qrp_dot: one row of the matrix-vector product
// Three register stages: split partial products, full products, and the row
// sum with half the norm added for rounding.
// ----------------------------------------------------------------------------
module qrp_dot
  import qrp_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 en,
  input  mat_t [2:0]                           row,
  input  logic [2:0][COORD_WIDTH-1:0]          vec,
  input  norm_t                                norm_in,
  output logic signed [MAT_W+COORD_WIDTH+1:0]  sum,
  output norm_t                                norm_out
);

  localparam int PPW = MAT_W - MLO_W + COORD_WIDTH;
  localparam int PW  = MAT_W + COORD_WIDTH;
  localparam int SW  = MAT_W + COORD_WIDTH + 2;

  logic signed [PPW-1:0] lo_p [3];
  logic signed [PPW-1:0] hi_p [3];
  logic signed [PW-1:0]  full [3];
  norm_t                 nd1, nd2;

  // Partial products: low part of each entry unsigned, high part signed.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        lo_p[j] <= $signed({1'b0, row[j][MLO_W-1:0]}) * $signed(vec[j]);
        hi_p[j] <= $signed(row[j][MAT_W-1:MLO_W]) * $signed(vec[j]);
      end
      nd1 <= norm_in;
    end
  end

  // Recombine the two halves of each product.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        full[j] <= (PW'(hi_p[j]) <<< MLO_W) + PW'(lo_p[j]);
      end
      nd2 <= nd1;
    end
  end

  // Row sum plus half the norm, so that a floor division rounds.
  always_ff @(posedge clk) begin
    if (en) begin
      sum      <= SW'(full[0]) + SW'(full[1]) + SW'(full[2]) + SW'(nd2 >> 1);
      norm_out <= nd2;
    end
  end

endmodule

// ===== design/qrp_divider.sv =====
// ----------------------------------------------------------------------------
// qrp_divider: pipelined floor division by the norm
// One stage takes the magnitude, one restoring stage per quotient bit
// follows, and a last stage restores the sign with floor semantics.
// ----------------------------------------------------------------------------
module qrp_divider
  import qrp_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [MAT_W+COORD_WIDTH+1:0] num,
  input  norm_t                               norm_in,
  output logic signed [COORD_WIDTH+2:0]       quot,
  output norm_t                               norm_out
);

  localparam int QW = COORD_WIDTH + 2;
  localparam int SW = MAT_W + COORD_WIDTH + 2;

  logic [SW-1:0]    mag_c;
  logic [REM_W-1:0] rem  [QW+1];
  logic [QW-1:0]    low  [QW+1];
  logic [QW-1:0]    quo  [QW+1];
  norm_t            nrm  [QW+1];
  logic             ng   [QW+1];
  logic [QW:0]      qext;

  assign mag_c = num[SW-1] ? SW'(-num) : SW'(num);

  // Magnitude stage: the top bits form the first partial remainder.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= REM_W'(mag_c >> QW);
      low[0] <= mag_c[QW-1:0];
      quo[0] <= '0;
      nrm[0] <= norm_in;
      ng[0]  <= num[SW-1];
    end
  end

  // Restoring stages, most significant quotient bit first.
  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [REM_W:0] trial;
    logic           ge;

    assign trial = {rem[s], low[s][QW-1-s]};
    assign ge    = (trial >= (REM_W+1)'(nrm[s]));

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? REM_W'(trial - (REM_W+1)'(nrm[s])) : REM_W'(trial);
        low[s+1] <= low[s];
        quo[s+1] <= {quo[s][QW-2:0], ge};
        nrm[s+1] <= nrm[s];
        ng[s+1]  <= ng[s];
      end
    end
  end

  assign qext = {1'b0, quo[QW]};

  // Sign stage: a negative dividend with a remainder rounds down once more.
  always_ff @(posedge clk) begin
    if (en) begin
      quot     <= ng[QW] ? $signed(-qext - (QW+1)'(rem[QW] != '0)) : $signed(qext);
      norm_out <= nrm[QW];
    end
  end

endmodule

// ===== design/quaternion_rotate_point.sv =====
// ----------------------------------------------------------------------------
// quaternion_rotate_point: rotate 3D points by a configured quaternion
// Top level with the register file, the pipeline control and the
// saturating output register.
// ----------------------------------------------------------------------------
// The block takes one point per clock cycle and passes each one through
// the pipeline: two stages form the scaled rotation matrix, three form the
// dot products and add half the norm for rounding, the floor divider by the
// squared norm spends one stage per quotient bit (COORD_WIDTH + 2) plus a
// magnitude and a sign stage, and a last stage saturates and holds the
// result. The whole pipeline advances together and stops while a result
// waits at the output. Any non-zero quaternion is accepted, since its scale
// cancels; a zero quaternion gives zero coordinates with zero_quaternion set.
// Write the quaternion registers only while no point is in flight.
module quaternion_rotate_point
  import qrp_pkg::*;
#(
  parameter int COORD_WIDTH    = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          point_valid,
  output logic                          point_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic                          rotated_valid,
  input  logic                          rotated_ready,
  output logic signed [COORD_WIDTH-1:0] rotated_x,
  output logic signed [COORD_WIDTH-1:0] rotated_y,
  output logic signed [COORD_WIDTH-1:0] rotated_z,
  output logic                          saturated,
  output logic                          zero_quaternion
);

  localparam int QW  = COORD_WIDTH + 2;
  localparam int SW  = MAT_W + COORD_WIDTH + 2;
  localparam int LAT = QW + 8;
  localparam logic signed [QW:0] HI = {4'b0000, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [QW:0] LO = {4'b1111, {(COORD_WIDTH-1){1'b0}}};

  quat_t quat_w, quat_x, quat_y, quat_z;
  logic  [1:0] reg_idx;
  logic  en;
  logic  [LAT-1:0] valid;

  logic [COORD_WIDTH-1:0] pd1 [3];
  logic [COORD_WIDTH-1:0] pd2 [3];

  norm_t      mnorm;
  mat_t [8:0] mat;

  logic signed [SW-1:0] dsum  [3];
  norm_t                dnorm [3];
  logic signed [QW:0]   quot  [3];
  norm_t                qnorm [3];

  logic signed [COORD_WIDTH-1:0] clip [3];
  logic       sat [3];
  logic       zero_q;

  // Register file on the configuration port.
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w <= QUAT_W'(32'd1 << QUAT_FRAC_BITS);
      quat_x <= '0;
      quat_y <= '0;
      quat_z <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_QUAT_W: quat_w <= pwdata[QUAT_W-1:0];
        REG_QUAT_X: quat_x <= pwdata[QUAT_W-1:0];
        REG_QUAT_Y: quat_y <= pwdata[QUAT_W-1:0];
        REG_QUAT_Z: quat_z <= pwdata[QUAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_QUAT_W: prdata = DATA_W'($unsigned(quat_w));
      REG_QUAT_X: prdata = DATA_W'($unsigned(quat_x));
      REG_QUAT_Y: prdata = DATA_W'($unsigned(quat_y));
      REG_QUAT_Z: prdata = DATA_W'($unsigned(quat_z));
      default:    prdata = '0;
    endcase
  end

  // The pipeline moves as one unless a finished result is held at the output.
  assign en            = !valid[LAT-1] || rotated_ready;
  assign point_ready   = en;
  assign rotated_valid = valid[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[LAT-2:0], point_valid};
    end
  end

  // Points wait alongside the matrix stages.
  always_ff @(posedge clk) begin
    if (en) begin
      pd1[0] <= point_x;
      pd1[1] <= point_y;
      pd1[2] <= point_z;
      for (int j = 0; j < 3; j++) begin
        pd2[j] <= pd1[j];
      end
    end
  end

  qrp_matrix u_matrix (
    .clk  (clk),
    .en   (en),
    .qw   (quat_w),
    .qx   (quat_x),
    .qy   (quat_y),
    .qz   (quat_z),
    .norm (mnorm),
    .mat  (mat)
  );

  for (genvar r = 0; r < 3; r++) begin : g_row
    qrp_dot #(.COORD_WIDTH(COORD_WIDTH)) u_dot (
      .clk      (clk),
      .en       (en),
      .row      ({mat[3*r+2], mat[3*r+1], mat[3*r]}),
      .vec      ({pd2[2], pd2[1], pd2[0]}),
      .norm_in  (mnorm),
      .sum      (dsum[r]),
      .norm_out (dnorm[r])
    );

    qrp_divider #(.COORD_WIDTH(COORD_WIDTH)) u_div (
      .clk      (clk),
      .en       (en),
      .num      (dsum[r]),
      .norm_in  (dnorm[r]),
      .quot     (quot[r]),
      .norm_out (qnorm[r])
    );

    // Clip each coordinate to the output range.
    always_comb begin
      sat[r] = 1'b0;
      if (quot[r] > HI) begin
        clip[r] = HI[COORD_WIDTH-1:0];
        sat[r]  = 1'b1;
      end else if (quot[r] < LO) begin
        clip[r] = LO[COORD_WIDTH-1:0];
        sat[r]  = 1'b1;
      end else begin
        clip[r] = quot[r][COORD_WIDTH-1:0];
      end
    end
  end

  // A zero norm, carried along with the quotient, marks the zero quaternion.
  assign zero_q = (qnorm[0] == '0);

  // Output register.
  always_ff @(posedge clk) begin
    if (en) begin
      rotated_x       <= zero_q ? '0 : clip[0];
      rotated_y       <= zero_q ? '0 : clip[1];
      rotated_z       <= zero_q ? '0 : clip[2];
      saturated       <= !zero_q && (sat[0] || sat[1] || sat[2]);
      zero_quaternion <= zero_q;
    end
  end

endmodule
